### rtl/shell_word_tokenizer_core_defines.svh
// Assertion helpers used by the tokenizer RTL.
// Every check is sampled on the rising clock and is switched off while reset is low.
`ifndef SHELL_WORD_TOKENIZER_CORE_DEFINES_SVH
`define SHELL_WORD_TOKENIZER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define SWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed one cycle later");

`endif

### rtl/swt_pkg.sv
`timescale 1ns / 1ps
package swt_pkg;

    localparam int MaxResults = 4;
    localparam int NumSlots   = 6;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_DOUBLE = 2'd2,
        MODE_ANSI   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_EOI  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       last_result;
    } t_out_item;

    // All results caused by one input item, in order.
    typedef struct packed {
        logic [2:0]                      count;
        t_out_item [MaxResults-1:0]      items;
    } t_bundle;

    typedef struct packed {
        logic    valid;
        t_bundle bundle;
    } t_qlink;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
    endfunction

    function automatic logic [7:0] ansi_map(input logic [7:0] c);
        logic [7:0] m;
        case (c)
            CH_LOW_N: m = CH_LF;
            CH_LOW_T: m = CH_TAB;
            CH_LOW_R: m = CH_CR;
            default:  m = c;
        endcase
        return m;
    endfunction

    function automatic t_out_item mk_byte(input logic [7:0] c);
        t_out_item r;
        r.kind        = KIND_BYTE;
        r.out_byte    = c;
        r.last_result = 1'b0;
        return r;
    endfunction

    function automatic t_out_item mk_mark(input t_kind k);
        t_out_item r;
        r.kind        = k;
        r.out_byte    = 8'h00;
        r.last_result = 1'b0;
        return r;
    endfunction

endpackage

### rtl/swt_front.sv
`timescale 1ns / 1ps
`include "shell_word_tokenizer_core_defines.svh"
module swt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  swt_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_stall,
    output swt_pkg::t_qlink   o_push
);
    import swt_pkg::*;

    t_mode r_mode, n_mode;
    logic  r_esc, n_esc;
    logic  r_dol, n_dol;
    logic  r_tok, n_tok;

    logic                     w_accept;
    logic [7:0]               w_c;
    logic                     w_plain;
    logic [NumSlots-1:0]      w_cv;
    t_out_item [NumSlots-1:0] w_ci;
    t_bundle                  w_bundle;
    logic [2:0]               w_n;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;
    assign w_c      = i_item.byte_value;

    // Slot order: held dollar, main result, dollar at line end, backslash at
    // line end, token end at line end, end of input.
    always_comb begin
        n_mode  = r_mode;
        n_esc   = r_esc;
        n_dol   = r_dol;
        n_tok   = r_tok;
        w_plain = 1'b0;
        w_cv    = '0;
        w_ci    = '0;

        case (r_mode)
            MODE_SINGLE: begin
                if (w_c == CH_SQUOTE) begin
                    n_mode = MODE_NORMAL;
                end else begin
                    w_cv[1] = 1'b1;
                    w_ci[1] = mk_byte(w_c);
                end
            end
            MODE_DOUBLE, MODE_ANSI: begin
                if (r_esc) begin
                    n_esc   = 1'b0;
                    w_cv[1] = 1'b1;
                    w_ci[1] = mk_byte((r_mode == MODE_ANSI) ? ansi_map(w_c) : w_c);
                end else if (w_c == CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if (w_c == ((r_mode == MODE_ANSI) ? CH_SQUOTE : CH_DQUOTE)) begin
                    n_mode = MODE_NORMAL;
                end else begin
                    w_cv[1] = 1'b1;
                    w_ci[1] = mk_byte(w_c);
                end
            end
            default: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                    if (is_space(w_c)) begin
                        if (r_tok) begin
                            w_cv[1] = 1'b1;
                            w_ci[1] = mk_mark(KIND_END);
                        end
                        n_tok = 1'b0;
                    end else begin
                        w_cv[1] = 1'b1;
                        w_ci[1] = mk_byte(w_c);
                        n_tok   = 1'b1;
                    end
                end else if (r_dol) begin
                    n_dol = 1'b0;
                    if (w_c == CH_SQUOTE) begin
                        n_mode = MODE_ANSI;
                        n_tok  = 1'b1;
                    end else begin
                        w_cv[0] = 1'b1;
                        w_ci[0] = mk_byte(CH_DOLLAR);
                        n_tok   = 1'b1;
                        w_plain = 1'b1;
                    end
                end else begin
                    w_plain = 1'b1;
                end
            end
        endcase

        if (w_plain) begin
            if (is_space(w_c)) begin
                if (n_tok) begin
                    w_cv[1] = 1'b1;
                    w_ci[1] = mk_mark(KIND_END);
                end
                n_tok = 1'b0;
            end else begin
                case (w_c)
                    CH_BSLASH: n_esc = 1'b1;
                    CH_SQUOTE: begin
                        n_mode = MODE_SINGLE;
                        n_tok  = 1'b1;
                    end
                    CH_DQUOTE: begin
                        n_mode = MODE_DOUBLE;
                        n_tok  = 1'b1;
                    end
                    CH_DOLLAR: n_dol = 1'b1;
                    default: begin
                        w_cv[1] = 1'b1;
                        w_ci[1] = mk_byte(w_c);
                        n_tok   = 1'b1;
                    end
                endcase
            end
        end

        if (i_item.last_byte) begin
            if (n_dol) begin
                w_cv[2] = 1'b1;
                w_ci[2] = mk_byte(CH_DOLLAR);
                n_tok   = 1'b1;
            end
            // A dangling backslash survives only inside quotes.
            if (n_esc && n_mode != MODE_NORMAL) begin
                w_cv[3] = 1'b1;
                w_ci[3] = mk_byte(CH_BSLASH);
            end
            if (n_tok) begin
                w_cv[4] = 1'b1;
                w_ci[4] = mk_mark(KIND_END);
            end
            w_cv[5] = 1'b1;
            w_ci[5] = mk_mark(KIND_EOI);
            n_mode  = MODE_NORMAL;
            n_esc   = 1'b0;
            n_dol   = 1'b0;
            n_tok   = 1'b0;
        end
    end

    // Pack the live slots into consecutive entries.
    always_comb begin
        w_n      = 3'd0;
        w_bundle = '0;
        for (int i = 0; i < NumSlots; i++) begin
            if (w_cv[i]) begin
                if (w_n < 3'(MaxResults)) begin
                    w_bundle.items[w_n[1:0]] = w_ci[i];
                end
                w_n = w_n + 3'd1;
            end
        end
        w_bundle.count = w_n;
        for (int j = 0; j < MaxResults; j++) begin
            w_bundle.items[j].last_result = ((3'(j) + 3'd1) == w_n);
        end
    end

    assign o_push.valid  = w_accept && (w_bundle.count != 3'd0);
    assign o_push.bundle = w_bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_esc  <= 1'b0;
            r_dol  <= 1'b0;
            r_tok  <= 1'b0;
        end else if (w_accept) begin
            r_mode <= n_mode;
            r_esc  <= n_esc;
            r_dol  <= n_dol;
            r_tok  <= n_tok;
        end
    end

    `SWT_ASSERT_NEXT(a_line_end_resets, i_clk, i_rst_n, w_accept && i_item.last_byte, r_mode == MODE_NORMAL && !r_esc && !r_dol && !r_tok)
    `SWT_ASSERT_SAME(a_line_end_pushes, i_clk, i_rst_n, w_accept && i_item.last_byte, o_push.valid)
    `SWT_ASSERT_SAME(a_count_in_range, i_clk, i_rst_n, o_push.valid, o_push.bundle.count != 3'd0 && o_push.bundle.count <= 3'(MaxResults))

endmodule

### rtl/swt_queue.sv
`timescale 1ns / 1ps
module swt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  swt_pkg::t_qlink i_push,
    input  logic            i_pop,
    output logic            o_full,
    output swt_pkg::t_qlink o_head
);
    import swt_pkg::*;

    t_bundle    r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    logic       w_do_pop;

    assign o_full        = (r_count == 2'd2);
    assign o_head.valid  = (r_count != 2'd0);
    assign o_head.bundle = r_mem[r_rd];
    assign w_do_pop      = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wr <= ~r_wr;
            end
            if (w_do_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push.valid, w_do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/swt_back.sv
`timescale 1ns / 1ps
module swt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swt_pkg::t_qlink    i_head,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output swt_pkg::t_out_item o_item
);
    import swt_pkg::*;

    logic [1:0] r_sub, n_sub;
    logic       r_valid, n_valid;
    t_out_item  r_item, n_item;
    logic       w_load;
    logic       w_final;

    assign w_load  = !r_valid || !i_stall;
    assign w_final = ({1'b0, r_sub} == (i_head.bundle.count - 3'd1));

    always_comb begin
        n_sub   = r_sub;
        n_valid = r_valid;
        n_item  = r_item;
        o_pop   = 1'b0;
        if (w_load) begin
            n_valid = i_head.valid;
            if (i_head.valid) begin
                n_item = i_head.bundle.items[r_sub];
                if (w_final) begin
                    o_pop = 1'b1;
                    n_sub = 2'd0;
                end else begin
                    n_sub = r_sub + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_sub   <= n_sub;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/shell_word_tokenizer_core.sv
`timescale 1ns / 1ps
// Shell-style word splitter. Bytes of a command line enter on the input channel
// (i_valid / o_stall / i_item), one item per byte, with last_byte set on the
// final byte. Results leave on the output channel (o_valid / i_stall / o_item):
// token bytes, token-end marks and one end-of-input mark per line, with
// last_result set on the final result caused by each input byte.
// A byte is classified in the cycle it is accepted and its results, up to four,
// are written as one entry into a two-entry queue. While the receiver does not
// stall, the back end sends one result per cycle from an output register; a
// byte's results pass through its queue entry and then the output register.
// Throughput is one byte per cycle while each byte gives at most one result
// and the receiver does not stall; a byte giving several results sends them
// one after another, and bytes that only change state write no queue entry.
// The input stalls only when the queue is full.
// Reset clears the quote and escape state, empties the queue and drops any
// result not yet taken. While the receiver stalls, the output item is held
// and the queue keeps absorbing bytes until it fills.
module shell_word_tokenizer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  swt_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output swt_pkg::t_out_item o_item
);
    import swt_pkg::*;

    t_qlink w_push;
    t_qlink w_head;
    logic   w_full;
    logic   w_pop;

    swt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_full  (w_full),
        .o_stall (o_stall),
        .o_push  (w_push)
    );

    swt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    swt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule
